>>> src/mmq_pkg.sv
// shared types and constants of the matrix quantizer
package mmq_pkg;

    localparam int CoefsPerBlock = 64;
    localparam int PosWidth      = $clog2(CoefsPerBlock);
    localparam int QueueDepth    = 2;
    localparam int DivSteps      = 16;

    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_QINTRA  = 3'd1,
        ACT_QINTER  = 3'd2,
        ACT_DQINTRA = 3'd3,
        ACT_DQINTER = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } back_state_t;

    // one classified coefficient request on its way to the back end
    typedef struct packed {
        action_t            act;
        logic signed [11:0] coef;
        logic [4:0]         qscale;
        logic [7:0]         weight;
        logic [5:0]         dcs;
        logic               row_on;
        logic               first;
        logic               last;
    } mmq_op_t;

endpackage

>>> src/mmq_if.sv
// request channels of the matrix quantizer
interface mmq_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [11:0] coefficient;
    logic [5:0]         weight_index;
    logic [7:0]         weight_value;
    logic [4:0]         quant_scale;
    logic [5:0]         dc_scale;
    logic [7:0]         row_mask;
    modport source (output valid, action, coefficient, weight_index, weight_value,
                    quant_scale, dc_scale, row_mask, input ready);
    modport sink (input valid, action, coefficient, weight_index, weight_value,
                  quant_scale, dc_scale, row_mask, output ready);
endinterface

interface mmq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coefficient_out;
    logic               last;
    logic [20:0]        abs_sum;
    modport source (output valid, coefficient_out, last, abs_sum, input ready);
    modport sink (input valid, coefficient_out, last, abs_sum, output ready);
endinterface

interface mmq_cfg_if;
    logic valid;
    logic ready;
    logic intra_table;
    modport source (output valid, intra_table, input ready);
    modport sink (input valid, intra_table, output ready);
endinterface

>>> src/mpeg4_matrix_quantizer.sv
// top level of the matrix quantizer
//  channel | direction | payload
//  in_ch   | in        | action, coefficient, weight_index/value, scales, row_mask
//  out_ch  | out       | coefficient_out, last, abs_sum
//  cfg     | in        | intra_table
// quantization runs each coefficient through the 16-step shared divider in the back end
// (the divider is skipped when the divisor is zero)
// dequantization runs each coefficient through load, scale, product and finish steps
// load_weight requests write the weight store directly
// a two-entry queue lets the front keep accepting while the back end works or stalls
// reset clears position, sums and control; the weight store holds nothing until loaded
module mpeg4_matrix_quantizer
    import mmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mmq_in_if.sink    in_ch,
    mmq_out_if.source out_ch,
    mmq_cfg_if.sink   cfg
);

    logic    intra_table_reg;
    mmq_op_t front_op, queue_op;
    logic    front_valid, front_ready, queue_valid, queue_ready;

    // configuration register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            intra_table_reg <= 1'b0;
        else if (cfg.valid)
            intra_table_reg <= cfg.intra_table;
    end

    mmq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .op       (front_op),
        .op_valid (front_valid),
        .op_ready (front_ready)
    );

    mmq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (front_op),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_op     (queue_op),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    mmq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .intra_table (intra_table_reg),
        .op          (queue_op),
        .op_valid    (queue_valid),
        .op_ready    (queue_ready),
        .out_ch      (out_ch)
    );

endmodule

>>> src/mmq_front.sv
// front end: weight store, block position and request classification
module mmq_front
    import mmq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mmq_in_if.sink        in_ch,
    output mmq_op_t       op,
    output logic          op_valid,
    input  logic          op_ready
);

    logic [7:0]          weight_mem [CoefsPerBlock];
    logic [PosWidth-1:0] pos_reg, pos_next;
    logic                stage_valid_reg, stage_valid_next;
    mmq_op_t             stage_reg;
    logic [7:0]          weight_rd_reg;
    logic                accept, is_load, is_coef, pos_last;

    // decode the incoming request
    always_comb
    begin
        is_load = 1'b0;
        is_coef = 1'b0;
        case (action_t'(in_ch.action)) inside
            ACT_LOAD:                                         is_load = 1'b1;
            ACT_QINTRA, ACT_QINTER, ACT_DQINTRA, ACT_DQINTER: is_coef = 1'b1;
            default:                                          ;
        endcase
    end

    assign in_ch.ready = !stage_valid_reg || op_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign pos_last    = (pos_reg == PosWidth'(CoefsPerBlock - 1));

    // position and stage occupancy
    always_comb
    begin
        pos_next         = pos_reg;
        stage_valid_next = stage_valid_reg && !op_ready;
        if (accept && is_coef)
        begin
            pos_next         = pos_last ? '0 : pos_reg + 1'b1;
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // weight store with registered read
    always_ff @(posedge clk)
    begin
        if (accept && is_load)
            weight_mem[in_ch.weight_index] <= in_ch.weight_value;
        if (accept && is_coef)
            weight_rd_reg <= weight_mem[pos_reg];
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (accept && is_coef)
        begin
            stage_reg.act    <= action_t'(in_ch.action);
            stage_reg.coef   <= in_ch.coefficient;
            stage_reg.qscale <= in_ch.quant_scale;
            stage_reg.weight <= '0;
            stage_reg.dcs    <= in_ch.dc_scale;
            stage_reg.row_on <= in_ch.row_mask[pos_reg[PosWidth-1:3]];
            stage_reg.first  <= (pos_reg == '0);
            stage_reg.last   <= pos_last;
        end
    end

    always_comb
    begin
        op        = stage_reg;
        op.weight = weight_rd_reg;
    end
    assign op_valid = stage_valid_reg;

endmodule

>>> src/mmq_queue.sv
// short request queue between front and back end
module mmq_queue
    import mmq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mmq_op_t push_op,
    input  logic    push_valid,
    output logic    push_ready,
    output mmq_op_t pop_op,
    output logic    pop_valid,
    input  logic    pop_ready
);

    localparam int PtrWidth = $clog2(QueueDepth);

    mmq_op_t               slot_reg [QueueDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PtrWidth:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != (PtrWidth+1)'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_op     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

endmodule

>>> src/mmq_back.sv
// back end: step size, shared divider, dequant product and result register
module mmq_back
    import mmq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     intra_table,
    input  mmq_op_t  op,
    input  logic     op_valid,
    output logic     op_ready,
    mmq_out_if.source out_ch
);

    back_state_t        state_reg, state_next;
    mmq_op_t            op_reg;
    logic [13:0]        step_reg;
    logic [15:0]        num_reg;
    logic [14:0]        rem_reg;
    logic [13:0]        div_reg;
    logic [25:0]        prod_reg;
    logic [3:0]         cnt_reg;
    logic               par_reg;
    logic [20:0]        sum_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_coef_reg;
    logic               out_last_reg;
    logic [20:0]        out_sum_reg;

    logic               is_dc, is_quant, neg, fin_go;
    logic [11:0]        mag;
    logic [16:0]        qbias;
    logic [13:0]        divisor;
    logic [16:0]        numer;
    logic [15:0]        trial;
    logic [25:0]        dq_sum;
    logic [21:0]        dq_val;
    logic signed [15:0] res;
    logic               par_new;
    logic [20:0]        sum_new;

    // operand decode
    assign is_quant = (op_reg.act == ACT_QINTRA) || (op_reg.act == ACT_QINTER);
    assign is_dc    = op_reg.first &&
                      ((op_reg.act == ACT_QINTRA) || (op_reg.act == ACT_DQINTRA));
    assign neg      = op_reg.coef[11];
    assign mag      = neg ? 12'(-op_reg.coef) : 12'(op_reg.coef);
    assign qbias    = intra_table ? ((17'(step_reg) * 17'd3 + 17'd4) >> 3) : '0;
    assign divisor  = is_dc ? 14'(op_reg.dcs) : step_reg;
    assign numer    = is_dc ? (17'(mag) + 17'(op_reg.dcs >> 1)) : ({mag, 4'b0} + qbias);
    assign trial    = {rem_reg, num_reg[15]};

    assign op_ready = (state_reg == ST_IDLE);
    assign fin_go   = (state_reg == ST_FIN) && (!out_valid_reg || out_ch.ready);

    // result formation
    always_comb
    begin
        dq_sum  = prod_reg + ((is_dc || intra_table) ? 26'd0 : 26'(step_reg >> 1));
        dq_val  = is_dc ? dq_sum[21:0] : dq_sum[25:4];
        par_new = op_reg.first ? 1'b0 : par_reg;
        sum_new = op_reg.first ? '0 : sum_reg;
        if (is_quant)
        begin
            res = neg ? -$signed(num_reg) : $signed(num_reg);
        end
        else if (!neg)
        begin
            res = (dq_val > 22'd2047) ? 16'sd2047 : $signed(16'(dq_val));
        end
        else
        begin
            res = (dq_val > 22'd2048) ? -16'sd2048 : -$signed(16'(dq_val));
        end
        if (!is_quant && !is_dc && (op_reg.coef == '0))
            res = '0;
        if (op_reg.act == ACT_DQINTER)
        begin
            if (!op_reg.row_on)
                res = '0;
            par_new = par_new ^ res[0];
            if (op_reg.last && !par_new)
                res[0] = ~res[0];
        end
        if (op_reg.act == ACT_QINTER)
            sum_new = sum_new + 21'(num_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (op_valid) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_PREP;
            ST_PREP:  state_next = (is_quant && divisor != '0) ? ST_DIV : ST_FIN;
            ST_DIV:   if (cnt_reg == 4'(DivSteps - 1)) state_next = ST_FIN;
            ST_FIN:   if (fin_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            par_reg       <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                par_reg       <= par_new;
                sum_reg       <= sum_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg  <= op;
                cnt_reg <= '0;
            end
            ST_SCALE:
                step_reg <= {13'(op_reg.qscale) * 13'(op_reg.weight), 1'b0};
            ST_PREP:
            begin
                prod_reg <= 26'(mag) * 26'(divisor);
                num_reg  <= (divisor != '0) ? numer[15:0] : '0;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                if (trial >= 16'(div_reg))
                begin
                    rem_reg <= 15'(trial - 16'(div_reg));
                    num_reg <= {num_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[14:0];
                    num_reg <= {num_reg[14:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
                if (fin_go)
                begin
                    out_coef_reg <= res;
                    out_last_reg <= op_reg.last;
                    out_sum_reg  <= (op_reg.last && op_reg.act == ACT_QINTER) ? sum_new : '0;
                end
            end
        endcase
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.coefficient_out = out_coef_reg;
    assign out_ch.last            = out_last_reg;
    assign out_ch.abs_sum         = out_sum_reg;

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == 4'(DivSteps - 1)) |=> (state_reg == ST_FIN))
        else $error("divider did not finish after its last step");

    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("finished result not presented");

    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sum_reg != '0) |-> out_last_reg)
        else $error("level sum reported before the last coefficient");

endmodule
